>>> design/drf_pkg.sv
package drf_pkg;

   localparam int NODE_W         = 6;
   localparam int CNT_W          = 7;
   localparam int STAT_W         = 2;
   localparam int MAX_NODES_DEF  = 64;
   localparam int MAX_DEGREE_DEF = 8;

   localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0] path_node;
      logic              found;
      logic              last;
      logic [STAT_W-1:0] status;
   } drf_beat_type;

endpackage

>>> design/drf_engine.sv
module drf_engine #(
   parameter int MAX_NODES  = drf_pkg::MAX_NODES_DEF,
   parameter int MAX_DEGREE = drf_pkg::MAX_DEGREE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          opcode,
   input  logic [drf_pkg::NODE_W-1:0]    from_node,
   input  logic [drf_pkg::NODE_W-1:0]    to_node,
   input  logic [drf_pkg::CNT_W-1:0]     node_count,
   input  logic                          slot_free,
   output logic                          idle,
   output logic                          beat_load,
   output drf_pkg::drf_beat_type         beat
);
   import drf_pkg::*;

   localparam int SIDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int DEPTH_W = $clog2(MAX_NODES + 1);
   localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
   localparam int ADJ_N   = MAX_NODES * MAX_DEGREE;
   localparam int ADJ_AW  = (ADJ_N > 1) ? $clog2(ADJ_N) : 1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_EDGE     = 8'b0000_0010,
      ST_SCAN_DEG = 8'b0000_0100,
      ST_SCAN     = 8'b0000_1000,
      ST_POP      = 8'b0001_0000,
      ST_OUT_RD   = 8'b0010_0000,
      ST_OUT      = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } drf_state_type;

   function automatic logic [ADJ_AW-1:0] row_base(input logic [NODE_W-1:0] node);
      row_base = ADJ_AW'(int'(node) * MAX_DEGREE);
   endfunction

   // memories
   logic [NODE_W-1:0] adj_mem   [ADJ_N];
   logic [DEG_W-1:0]  deg_mem   [MAX_NODES];
   logic [NODE_W-1:0] stack_mem [MAX_NODES];

   logic [NODE_W-1:0] adj_rd_ff;
   logic [DEG_W-1:0]  deg_rd_ff;
   logic              deg_vld_rd_ff;
   logic [NODE_W-1:0] stack_rd_ff;

   logic [ADJ_AW-1:0] adj_ra, adj_wa;
   logic              adj_we;
   logic [NODE_W-1:0] adj_wd;
   logic [SIDX_W-1:0] deg_ra, deg_wa;
   logic              deg_we;
   logic [DEG_W-1:0]  deg_wd;
   logic [SIDX_W-1:0] stack_ra, stack_wa;
   logic              stack_we;
   logic [NODE_W-1:0] stack_wd;

   // control and working registers
   drf_state_type      state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [SIDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [NODE_W-1:0]  top_ff, top_in;
   logic [NODE_W-1:0]  dst_ff, dst_in;
   logic [ADJ_AW-1:0]  base_ff, base_in;
   logic [DEG_W-1:0]   idx_ff, idx_in;
   logic [DEG_W-1:0]   deg_ff, deg_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] deg_vld_ff, deg_vld_in;

   logic [CNT_W-1:0]   limit;
   logic               out_of_range;
   logic [DEG_W-1:0]   deg_eff;
   logic               target_ok;
   logic               pop_now;
   logic               out_last;

   always_comb begin
      limit        = (node_count < CNT_W'(MAX_NODES)) ? node_count : CNT_W'(MAX_NODES);
      out_of_range = ({1'b0, from_node} >= limit) || ({1'b0, to_node} >= limit);
      deg_eff      = deg_vld_rd_ff ? deg_rd_ff : '0;
      target_ok    = ({1'b0, adj_rd_ff} < CNT_W'(MAX_NODES)) &&
                     !visited_ff[adj_rd_ff[SIDX_W-1:0]];
      out_last     = (DEPTH_W'(out_idx_ff) + DEPTH_W'(1)) == depth_ff;
   end

   always_comb begin
      state_in   = state_ff;
      depth_in   = depth_ff;
      out_idx_in = out_idx_ff;
      top_in     = top_ff;
      dst_in     = dst_ff;
      base_in    = base_ff;
      idx_in     = idx_ff;
      deg_in     = deg_ff;
      status_in  = status_ff;
      visited_in = visited_ff;
      deg_vld_in = deg_vld_ff;
      pop_now    = 1'b0;

      adj_we   = 1'b0;
      adj_wa   = ADJ_AW'(base_ff + ADJ_AW'(deg_eff));
      adj_wd   = dst_ff;
      deg_we   = 1'b0;
      deg_wa   = top_ff[SIDX_W-1:0];
      deg_wd   = DEG_W'(deg_eff + DEG_W'(1));
      stack_we = 1'b0;
      stack_wa = depth_ff[SIDX_W-1:0];
      stack_wd = adj_rd_ff;

      beat_load      = 1'b0;
      beat.path_node = '0;
      beat.found     = 1'b0;
      beat.last      = 1'b1;
      beat.status    = status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               top_in  = from_node;
               dst_in  = to_node;
               base_in = row_base(from_node);
               if (out_of_range) begin
                  status_in = STATUS_RANGE;
                  state_in  = ST_RESP;
               end else if (opcode == OP_EDGE) begin
                  state_in = ST_EDGE;
               end else if (from_node == to_node) begin
                  status_in = STATUS_OK;
                  state_in  = ST_RESP;
               end else begin
                  visited_in = '0;
                  visited_in[from_node[SIDX_W-1:0]] = 1'b1;
                  stack_we  = 1'b1;
                  stack_wa  = '0;
                  stack_wd  = from_node;
                  depth_in  = DEPTH_W'(1);
                  status_in = STATUS_OK;
                  state_in  = ST_SCAN_DEG;
               end
            end
         end
         ST_EDGE: begin
            if (deg_eff >= DEG_W'(MAX_DEGREE)) begin
               status_in = STATUS_FULL;
            end else begin
               adj_we = 1'b1;
               deg_we = 1'b1;
               deg_vld_in[top_ff[SIDX_W-1:0]] = 1'b1;
               status_in = STATUS_OK;
            end
            state_in = ST_RESP;
         end
         ST_SCAN_DEG: begin
            deg_in = deg_eff;
            idx_in = '0;
            if (deg_eff == '0) begin
               pop_now = 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (target_ok) begin
               stack_we = 1'b1;
               visited_in[adj_rd_ff[SIDX_W-1:0]] = 1'b1;
               depth_in = DEPTH_W'(depth_ff + DEPTH_W'(1));
               top_in   = adj_rd_ff;
               base_in  = row_base(adj_rd_ff);
               if (adj_rd_ff == dst_ff) begin
                  out_idx_in = '0;
                  state_in   = ST_OUT_RD;
               end else begin
                  state_in = ST_SCAN_DEG;
               end
            end else if ((DEG_W + 1)'(idx_ff) + (DEG_W + 1)'(1) < (DEG_W + 1)'(deg_ff)) begin
               idx_in = DEG_W'(idx_ff + DEG_W'(1));
            end else begin
               pop_now = 1'b1;
            end
         end
         ST_POP: begin
            top_in   = stack_rd_ff;
            base_in  = row_base(stack_rd_ff);
            state_in = ST_SCAN_DEG;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            beat.path_node = stack_rd_ff;
            beat.found     = 1'b1;
            beat.last      = out_last;
            beat.status    = STATUS_OK;
            if (slot_free) begin
               beat_load = 1'b1;
               if (out_last) begin
                  depth_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = SIDX_W'(out_idx_ff + SIDX_W'(1));
                  state_in   = ST_OUT_RD;
               end
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               beat_load = 1'b1;
               depth_in  = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pop_now) begin
         if (depth_ff == DEPTH_W'(1)) begin
            depth_in  = '0;
            status_in = STATUS_OK;
            state_in  = ST_RESP;
         end else begin
            depth_in = DEPTH_W'(depth_ff - DEPTH_W'(1));
            state_in = ST_POP;
         end
      end
   end

   // read address selection
   always_comb begin
      case (state_ff)
         ST_IDLE: deg_ra = from_node[SIDX_W-1:0];
         ST_SCAN: deg_ra = adj_rd_ff[SIDX_W-1:0];
         ST_POP:  deg_ra = stack_rd_ff[SIDX_W-1:0];
         default: deg_ra = top_ff[SIDX_W-1:0];
      endcase
      case (state_ff)
         ST_SCAN: adj_ra = ADJ_AW'(base_ff + ADJ_AW'(idx_ff) + ADJ_AW'(1));
         default: adj_ra = base_ff;
      endcase
      case (state_ff)
         ST_OUT_RD, ST_OUT: stack_ra = out_idx_ff;
         default:           stack_ra = SIDX_W'(depth_ff - DEPTH_W'(2));
      endcase
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= adj_wd;
      end
      adj_rd_ff <= adj_mem[adj_ra];
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wa] <= deg_wd;
      end
      deg_rd_ff     <= deg_mem[deg_ra];
      deg_vld_rd_ff <= deg_vld_ff[deg_ra];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[stack_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         depth_ff   <= '0;
         visited_ff <= '0;
         deg_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
         deg_vld_ff <= deg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff <= out_idx_in;
      top_ff     <= top_in;
      dst_ff     <= dst_in;
      base_ff    <= base_in;
      idx_ff     <= idx_in;
      deg_ff     <= deg_in;
      status_ff  <= status_in;
   end

   assign idle = (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_NODES))
      else $error("stack depth beyond node count");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SCAN_DEG || state_ff == ST_POP) |->
      depth_ff != '0)
      else $error("search running on empty stack");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      beat_load |-> slot_free)
      else $error("result loaded into occupied slot");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (beat_load && beat.last) |=> (state_ff == ST_IDLE && depth_ff == '0))
      else $error("final beat did not end the item");
`endif

endmodule

>>> design/dfs_route_finder.sv
// Depth-first route finder over a small directed graph.
// Request channel (req_valid / req_stall): one beat per command. opcode 0 adds
// the edge from_node -> to_node, opcode 1 searches a route from from_node to
// to_node. A beat is taken when req_valid is high and req_stall is low; the
// block raises req_stall while it works on a command.
// Response channel (rsp_valid / rsp_stall): an edge load or a rejected command
// gives one beat. A query gives either the path, one node per beat from origin
// to destination with rsp_found set, or one not-found beat; rsp_last marks the
// final beat of each command.
// A rejected command, or a query whose origin is its destination, goes
// straight to the response state; an edge load first passes through the
// edge-write state. A query otherwise starts, then reads the degree of each
// node it enters or returns to, examines adjacency entries and pops, then
// reads each path beat from the stack before it shows it; the single read
// port of each memory sets this order. The next command is taken once the
// final beat sits in the output register.
// csr channel writes node_count; write it only while the block is quiet.
// Reset (synchronous) empties all adjacency lists and sets node_count to 64.
// When rsp_stall is high the output register holds its beat and the engine
// waits to load the next beat; nothing is dropped.
module dfs_route_finder #(
   parameter int MAX_NODES  = drf_pkg::MAX_NODES_DEF,
   parameter int MAX_DEGREE = drf_pkg::MAX_DEGREE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [drf_pkg::NODE_W-1:0]  req_from_node,
   input  logic [drf_pkg::NODE_W-1:0]  req_to_node,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [drf_pkg::NODE_W-1:0]  rsp_path_node,
   output logic                        rsp_found,
   output logic                        rsp_last,
   output logic [drf_pkg::STAT_W-1:0]  rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [drf_pkg::CNT_W-1:0]   csr_node_count
);
   import drf_pkg::*;

   logic             eng_idle;
   logic             beat_load;
   drf_beat_type     beat;
   logic             slot_free;
   logic             start;

   logic             rsp_valid_ff, rsp_valid_in;
   drf_beat_type     rsp_beat_ff, rsp_beat_in;
   logic [CNT_W-1:0] node_count_ff, node_count_in;

   assign req_stall = !eng_idle;
   assign start     = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   drf_engine #(
      .MAX_NODES  (MAX_NODES),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .opcode     (req_opcode),
      .from_node  (req_from_node),
      .to_node    (req_to_node),
      .node_count (node_count_ff),
      .slot_free  (slot_free),
      .idle       (eng_idle),
      .beat_load  (beat_load),
      .beat       (beat)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_beat_in   = rsp_beat_ff;
      node_count_in = node_count_ff;
      if (beat_load) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = beat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RST;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_path_node = rsp_beat_ff.path_node;
   assign rsp_found     = rsp_beat_ff.found;
   assign rsp_last      = rsp_beat_ff.last;
   assign rsp_status    = rsp_beat_ff.status;

endmodule
